// ----- rtl/rtp_pkg.sv -----
// rtp_pkg: shared constants, sideband flag type and arctangent table
// for the rectangular to polar converter; no dependencies
package rtp_pkg;

   // cordic vectoring: input prescale, iteration count, fine angle scale
   localparam int PRESCALE     = 20;
   localparam int CORDIC_ITERS = 20;
   localparam int FINE_BITS    = 19;

   // fine angle accumulator width, signed, holds the sum of all table entries
   localparam int Z_WIDTH = 28;

   // angles in whole degrees
   localparam int DEG_QUARTER = 90;
   localparam int DEG_HALF    = 180;
   localparam int DEG_THREE_Q = 270;
   localparam int DEG_FULL    = 360;

   // quadrant and axis flags that travel with each item
   typedef struct packed {
      logic re_neg;
      logic im_neg;
      logic re_zero;
      logic im_zero;
   } flags_type;

   // atan(2^-i) in units of 2^-19 degree
   function automatic logic signed [Z_WIDTH-1:0] atan_fine(input logic [4:0] idx);
      logic signed [Z_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 28'sd23592960;
         5'd1:    val = 28'sd13927738;
         5'd2:    val = 28'sd7359034;
         5'd3:    val = 28'sd3735561;
         5'd4:    val = 28'sd1875029;
         5'd5:    val = 28'sd938429;
         5'd6:    val = 28'sd469329;
         5'd7:    val = 28'sd234679;
         5'd8:    val = 28'sd117341;
         5'd9:    val = 28'sd58671;
         5'd10:   val = 28'sd29335;
         5'd11:   val = 28'sd14668;
         5'd12:   val = 28'sd7334;
         5'd13:   val = 28'sd3667;
         5'd14:   val = 28'sd1833;
         5'd15:   val = 28'sd917;
         5'd16:   val = 28'sd458;
         5'd17:   val = 28'sd229;
         5'd18:   val = 28'sd115;
         5'd19:   val = 28'sd57;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/rtp_stage.sv -----
// rtp_stage: one registered pipeline step, a cordic vectoring iteration
// and a square root digit step side by side; depends on rtp_pkg
module rtp_stage #(
   parameter int DATA_WIDTH = 16,
   parameter int STAGE      = 0
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   input  rtp_pkg::flags_type                           in_flags,
   input  logic signed [DATA_WIDTH+rtp_pkg::PRESCALE+1:0] in_x,
   input  logic signed [DATA_WIDTH+rtp_pkg::PRESCALE+1:0] in_y,
   input  logic signed [rtp_pkg::Z_WIDTH-1:0]           in_z,
   input  logic        [2*DATA_WIDTH-1:0]               in_rem,
   input  logic        [2*DATA_WIDTH-1:0]               in_res,
   output logic                                         out_valid,
   output rtp_pkg::flags_type                           out_flags,
   output logic signed [DATA_WIDTH+rtp_pkg::PRESCALE+1:0] out_x,
   output logic signed [DATA_WIDTH+rtp_pkg::PRESCALE+1:0] out_y,
   output logic signed [rtp_pkg::Z_WIDTH-1:0]           out_z,
   output logic        [2*DATA_WIDTH-1:0]               out_rem,
   output logic        [2*DATA_WIDTH-1:0]               out_res
);

   localparam int XW = DATA_WIDTH + rtp_pkg::PRESCALE + 2;
   localparam int ZW = rtp_pkg::Z_WIDTH;
   localparam int SW = 2 * DATA_WIDTH;

   logic                  valid_ff;
   rtp_pkg::flags_type    flags_ff;
   logic signed [XW-1:0]  x_ff, x_in;
   logic signed [XW-1:0]  y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic        [SW-1:0]  rem_ff, rem_in;
   logic        [SW-1:0]  res_ff, res_in;

   generate
      if (STAGE < rtp_pkg::CORDIC_ITERS) begin : g_cordic
         localparam logic [XW-1:0] RND = (XW'(1) << STAGE) - XW'(1);
         logic signed [XW-1:0] bias_x, bias_y, dx, dy;
         logic signed [ZW-1:0] step;
         logic                 y_pos;

         // shift toward zero: bias negative values before the arithmetic shift
         assign bias_x = in_x[XW-1] ? $signed(RND) : '0;
         assign bias_y = in_y[XW-1] ? $signed(RND) : '0;
         assign dx     = (in_y + bias_y) >>> STAGE;
         assign dy     = (in_x + bias_x) >>> STAGE;
         assign y_pos  = !in_y[XW-1] && (in_y != '0);
         assign step   = rtp_pkg::atan_fine(5'(STAGE));
         assign x_in   = y_pos ? in_x + dx : in_x - dx;
         assign y_in   = y_pos ? in_y - dy : in_y + dy;
         assign z_in   = y_pos ? in_z + step : in_z - step;
      end else begin : g_cordic_hold
         assign x_in = in_x;
         assign y_in = in_y;
         assign z_in = in_z;
      end

      if (STAGE < DATA_WIDTH) begin : g_sqrt
         localparam logic [SW-1:0] BIT = SW'(1) << (2 * (DATA_WIDTH - 1 - STAGE));
         logic [SW-1:0] trial;
         logic          take;

         assign trial  = in_res + BIT;
         assign take   = in_rem >= trial;
         assign rem_in = take ? in_rem - trial : in_rem;
         assign res_in = take ? (in_res >> 1) + BIT : in_res >> 1;
      end else begin : g_sqrt_hold
         assign rem_in = in_rem;
         assign res_in = in_res;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= in_flags;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      rem_ff   <= rem_in;
      res_ff   <= res_in;
   end

   assign out_valid = valid_ff;
   assign out_flags = flags_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_rem   = rem_ff;
   assign out_res   = res_ff;

endmodule

// ----- rtl/rectangular_to_polar.sv -----
// rectangular_to_polar: pipelined magnitude (exact rounded square root) and
// cordic angle of a fixed point complex value; depends on rtp_pkg, rtp_stage
// from start to result transfer an item passes the absolute value, square, sum,
// iteration, finishing and output registers; 20 cordic iterations and DATA_WIDTH root
// digits run one per stage; with busy low one item enters, one result leaves per cycle
// busy is high only during reset; reset clears all valid bits, the receiver cannot stall
module rectangular_to_polar #(
   parameter int DATA_WIDTH      = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [DATA_WIDTH-1:0]  req_real_part,
   input  logic signed [DATA_WIDTH-1:0]  req_imag_part,
   output logic                          rsp_strobe,
   output logic        [DATA_WIDTH-1:0]  rsp_magnitude,
   output logic        [ANGLE_FRAC_BITS+8:0] rsp_angle_deg
);

   localparam int XW       = DATA_WIDTH + rtp_pkg::PRESCALE + 2;
   localparam int ZW       = rtp_pkg::Z_WIDTH;
   localparam int SW       = 2 * DATA_WIDTH;
   localparam int AW       = 9 + ANGLE_FRAC_BITS;
   localparam int N_STAGES = (rtp_pkg::CORDIC_ITERS > DATA_WIDTH) ?
                             rtp_pkg::CORDIC_ITERS : DATA_WIDTH;
   localparam int LATENCY  = N_STAGES + 5;
   localparam int ASHIFT   = rtp_pkg::FINE_BITS - ANGLE_FRAC_BITS;

   localparam logic [ZW-1:0] HALF_LSB = ZW'(1) << (ASHIFT - 1);
   localparam logic [ZW-1:0] TOP_REF  = ZW'(rtp_pkg::DEG_QUARTER) << ANGLE_FRAC_BITS;
   localparam logic [AW:0]   ANG_QUARTER = (AW+1)'(rtp_pkg::DEG_QUARTER) << ANGLE_FRAC_BITS;
   localparam logic [AW:0]   ANG_HALF    = (AW+1)'(rtp_pkg::DEG_HALF) << ANGLE_FRAC_BITS;
   localparam logic [AW:0]   ANG_THREE_Q = (AW+1)'(rtp_pkg::DEG_THREE_Q) << ANGLE_FRAC_BITS;
   localparam logic [AW:0]   ANG_FULL    = (AW+1)'(rtp_pkg::DEG_FULL) << ANGLE_FRAC_BITS;

   logic accept;

   // stage 1: absolute values and flags
   logic                   v1_ff;
   rtp_pkg::flags_type     flags1_ff, flags1_in;
   logic [DATA_WIDTH-1:0]  ax1_ff, ax1_in, ay1_ff, ay1_in;

   // stage 2: squares
   logic                   v2_ff;
   rtp_pkg::flags_type     flags2_ff;
   logic [DATA_WIDTH-1:0]  ax2_ff, ay2_ff;
   logic [SW-1:0]          sqx2_ff, sqx2_in, sqy2_ff, sqy2_in;

   // stage 3: sum of squares
   logic                   v3_ff;
   rtp_pkg::flags_type     flags3_ff;
   logic [DATA_WIDTH-1:0]  ax3_ff, ay3_ff;
   logic [SW-1:0]          sum3_ff, sum3_in;

   // iteration pipeline
   logic                   v_pipe     [0:N_STAGES];
   rtp_pkg::flags_type     flags_pipe [0:N_STAGES];
   logic signed [XW-1:0]   x_pipe     [0:N_STAGES];
   logic signed [XW-1:0]   y_pipe     [0:N_STAGES];
   logic signed [ZW-1:0]   z_pipe     [0:N_STAGES];
   logic [SW-1:0]          rem_pipe   [0:N_STAGES];
   logic [SW-1:0]          res_pipe   [0:N_STAGES];

   // finishing stage: rounding and clamping
   logic                   vf_ff;
   rtp_pkg::flags_type     flagsf_ff;
   logic [DATA_WIDTH-1:0]  magf_ff, magf_in;
   logic [AW-1:0]          reff_ff, reff_in;
   logic [ZW-1:0]          z_clip, z_round;

   // output stage
   logic                   out_v_ff;
   logic [DATA_WIDTH-1:0]  out_mag_ff;
   logic [AW-1:0]          out_ang_ff, out_ang_in;
   logic [AW:0]            ang_raw, ang_wrap;

   assign busy   = reset;
   assign accept = start && !busy;

   assign ax1_in = req_real_part[DATA_WIDTH-1] ? $unsigned(-req_real_part)
                                               : $unsigned(req_real_part);
   assign ay1_in = req_imag_part[DATA_WIDTH-1] ? $unsigned(-req_imag_part)
                                               : $unsigned(req_imag_part);
   assign flags1_in.re_neg  = req_real_part[DATA_WIDTH-1];
   assign flags1_in.im_neg  = req_imag_part[DATA_WIDTH-1];
   assign flags1_in.re_zero = req_real_part == '0;
   assign flags1_in.im_zero = req_imag_part == '0;

   assign sqx2_in = SW'(ax1_ff) * SW'(ax1_ff);
   assign sqy2_in = SW'(ay1_ff) * SW'(ay1_ff);
   assign sum3_in = sqx2_ff + sqy2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         vf_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= accept;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vf_ff    <= v_pipe[N_STAGES];
         out_v_ff <= vf_ff;
      end
   end

   always_ff @(posedge clock) begin
      flags1_ff  <= flags1_in;
      ax1_ff     <= ax1_in;
      ay1_ff     <= ay1_in;
      flags2_ff  <= flags1_ff;
      ax2_ff     <= ax1_ff;
      ay2_ff     <= ay1_ff;
      sqx2_ff    <= sqx2_in;
      sqy2_ff    <= sqy2_in;
      flags3_ff  <= flags2_ff;
      ax3_ff     <= ax2_ff;
      ay3_ff     <= ay2_ff;
      sum3_ff    <= sum3_in;
      flagsf_ff  <= flags_pipe[N_STAGES];
      magf_ff    <= magf_in;
      reff_ff    <= reff_in;
      out_mag_ff <= magf_ff;
      out_ang_ff <= out_ang_in;
   end

   // cordic starts from the prescaled absolute values, root from the sum
   assign v_pipe[0]     = v3_ff;
   assign flags_pipe[0] = flags3_ff;
   assign x_pipe[0]     = $signed({2'b00, ax3_ff, {rtp_pkg::PRESCALE{1'b0}}});
   assign y_pipe[0]     = $signed({2'b00, ay3_ff, {rtp_pkg::PRESCALE{1'b0}}});
   assign z_pipe[0]     = '0;
   assign rem_pipe[0]   = sum3_ff;
   assign res_pipe[0]   = '0;

   generate
      for (genvar j = 0; j < N_STAGES; j++) begin : g_stage
         rtp_stage #(
            .DATA_WIDTH (DATA_WIDTH),
            .STAGE      (j)
         ) u_stage (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (v_pipe[j]),
            .in_flags  (flags_pipe[j]),
            .in_x      (x_pipe[j]),
            .in_y      (y_pipe[j]),
            .in_z      (z_pipe[j]),
            .in_rem    (rem_pipe[j]),
            .in_res    (res_pipe[j]),
            .out_valid (v_pipe[j+1]),
            .out_flags (flags_pipe[j+1]),
            .out_x     (x_pipe[j+1]),
            .out_y     (y_pipe[j+1]),
            .out_z     (z_pipe[j+1]),
            .out_rem   (rem_pipe[j+1]),
            .out_res   (res_pipe[j+1])
         );
      end
   endgenerate

   // round to nearest: the remainder exceeds the root past the half point
   assign magf_in = (rem_pipe[N_STAGES] > res_pipe[N_STAGES]) ?
                    DATA_WIDTH'(res_pipe[N_STAGES] + SW'(1)) :
                    DATA_WIDTH'(res_pipe[N_STAGES]);

   // reference angle: clip below zero, round half up, clamp at a right angle
   assign z_clip  = z_pipe[N_STAGES][ZW-1] ? '0 : $unsigned(z_pipe[N_STAGES]);
   assign z_round = (z_clip + HALF_LSB) >> ASHIFT;
   assign reff_in = (z_round > TOP_REF) ? AW'(TOP_REF) : AW'(z_round);

   always_comb begin
      ang_raw = '0;
      if (flagsf_ff.re_zero && flagsf_ff.im_zero) begin
         ang_raw = '0;
      end else if (flagsf_ff.im_zero) begin
         ang_raw = flagsf_ff.re_neg ? ANG_HALF : '0;
      end else if (flagsf_ff.re_zero) begin
         ang_raw = flagsf_ff.im_neg ? ANG_THREE_Q : ANG_QUARTER;
      end else if (!flagsf_ff.re_neg && !flagsf_ff.im_neg) begin
         ang_raw = {1'b0, reff_ff};
      end else if (flagsf_ff.re_neg && !flagsf_ff.im_neg) begin
         ang_raw = ANG_HALF - {1'b0, reff_ff};
      end else if (flagsf_ff.re_neg) begin
         ang_raw = ANG_HALF + {1'b0, reff_ff};
      end else begin
         ang_raw = ANG_FULL - {1'b0, reff_ff};
      end
   end

   // a full turn folds back to zero
   assign ang_wrap   = (ang_raw >= ANG_FULL) ? ang_raw - ANG_FULL : ang_raw;
   assign out_ang_in = AW'(ang_wrap);

   assign rsp_strobe    = out_v_ff;
   assign rsp_magnitude = out_mag_ff;
   assign rsp_angle_deg = out_ang_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("start transfer without result after pipeline latency");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without matching start transfer");

   a_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_magnitude == '0) |-> rsp_angle_deg == '0)
      else $error("zero magnitude with nonzero angle");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> {1'b0, rsp_angle_deg} < ANG_FULL)
      else $error("angle outside one full turn");

   a_cordic_x: assert property (@(posedge clock) disable iff (reset)
      v_pipe[N_STAGES] |-> !x_pipe[N_STAGES][XW-1])
      else $error("cordic x went negative");

endmodule
